@@ src/ales_pkg.sv @@
package ales_pkg;

	// Field widths of the request and response items.
	localparam int OP_W     = 2;
	localparam int VERTEX_W = 6;
	localparam int COUNT_W  = 7;
	localparam int DEGREE_W = 6;
	localparam int STATUS_W = 2;
	localparam int TOTAL_W  = 12;

	// Default sizing of the graph store.
	localparam int DEF_MAX_VERTICES = 64;
	localparam int DEF_MAX_DEGREE   = 32;

	// Vertex count register value after reset.
	localparam logic [COUNT_W-1:0] VCOUNT_RESET = COUNT_W'(64);

	// Opcodes.
	localparam logic [OP_W-1:0] OP_ADD   = 2'd0;
	localparam logic [OP_W-1:0] OP_QUERY = 2'd1;
	localparam logic [OP_W-1:0] OP_LIST  = 2'd2;
	localparam logic [OP_W-1:0] OP_NOP   = 2'd3;

	// Response status codes.
	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

	typedef struct packed {
		logic [OP_W-1:0]     opcode;
		logic [VERTEX_W-1:0] source_vertex;
		logic [VERTEX_W-1:0] sink_vertex;
	} req_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic                edge_found;
		logic [DEGREE_W-1:0] source_degree;
		logic [TOTAL_W-1:0]  total_edges;
		logic [VERTEX_W-1:0] listed_sink;
		logic                sink_valid;
		logic                last;
	} rsp_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic clr_step;
		logic accept;
		logic eval;
		logic scan_start;
		logic scan_next;
		logic found_set;
		logic load_resp;
		logic load_item;
	} ctrl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic clr_done;
		logic need_scan;
		logic is_list;
		logic out_free;
		logic scan_more;
		logic hit;
	} dp_stat_t;

endpackage

@@ src/ales_ram.sv @@
module ales_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                                        clk,
	input  logic                                        we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                            wdata,
	input  logic                                        re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                            rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ src/ales_dpath.sv @@
module ales_dpath #(
	parameter int MAX_VERTICES = ales_pkg::DEF_MAX_VERTICES,
	parameter int MAX_DEGREE   = ales_pkg::DEF_MAX_DEGREE
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  ales_pkg::req_t                req,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [ales_pkg::COUNT_W-1:0]  cfg_data,
	output logic                          rsp_valid,
	input  logic                          rsp_ready,
	output ales_pkg::rsp_t                rsp,
	input  ales_pkg::ctrl_cmd_t           cmd,
	output ales_pkg::dp_stat_t            stat
);

	import ales_pkg::*;

	localparam int VA    = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
	localparam int DW    = $clog2(MAX_DEGREE + 1);
	localparam int IW    = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;
	localparam int DEPTH = MAX_VERTICES * MAX_DEGREE;
	localparam int SA    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CVW   = $clog2(MAX_VERTICES + 1);
	localparam int CW    = (CVW > COUNT_W) ? CVW : COUNT_W;

	// Item registers.
	logic [OP_W-1:0]     op_q;
	logic [VERTEX_W-1:0] src_q;
	logic [VERTEX_W-1:0] snk_q;
	logic [DW-1:0]       deg_q;
	logic [STATUS_W-1:0] status_q;
	logic                found_q;
	logic [IW-1:0]       idx_q;
	logic [TOTAL_W-1:0]  total_q;
	logic [COUNT_W-1:0]  vcount_q;
	logic [VA-1:0]       clr_cnt_q;
	logic                rsp_valid_q;
	rsp_t                rsp_q;

	// Memory ports.
	logic          dg_we;
	logic [VA-1:0] dg_waddr;
	logic [DW-1:0] dg_wdata;
	logic [DW-1:0] dg_rdata;
	logic          st_we;
	logic [SA-1:0] st_waddr;
	logic          st_re;
	logic [SA-1:0] st_raddr;
	logic [VERTEX_W-1:0] st_rdata;

	// Evaluation of the item once its degree is known.
	logic [CW-1:0]       n_eff;
	logic                src_ok;
	logic                snk_ok;
	logic [DW-1:0]       deg_eff;
	logic [DW-1:0]       deg_n;
	logic [STATUS_W-1:0] status_n;
	logic                need_scan;
	logic                add_ok;
	logic [VA-1:0]       src_idx;
	logic [SA-1:0]       base;
	logic [IW-1:0]       idx_n;

	assign src_idx = VA'(src_q);
	assign base    = SA'(src_idx * MAX_DEGREE);

	always_comb begin
		n_eff   = (CW'(vcount_q) > CW'(MAX_VERTICES)) ? CW'(MAX_VERTICES) : CW'(vcount_q);
		src_ok  = CW'(src_q) < n_eff;
		snk_ok  = CW'(snk_q) < n_eff;
		deg_eff = src_ok ? dg_rdata : '0;
		deg_n     = deg_eff;
		status_n  = ST_OK;
		need_scan = 1'b0;
		add_ok    = 1'b0;
		if (op_q == OP_NOP) begin
			status_n = ST_OK;
		end else if (!src_ok || (op_q != OP_LIST && !snk_ok)) begin
			status_n = ST_RANGE;
		end else begin
			case (op_q)
				OP_ADD: begin
					if (deg_eff == DW'(MAX_DEGREE)) begin
						status_n = ST_FULL;
					end else begin
						add_ok = 1'b1;
						deg_n  = deg_eff + DW'(1);
					end
				end
				default: begin
					need_scan = (deg_eff != '0);
				end
			endcase
		end
	end

	assign idx_n = cmd.scan_start ? '0 : idx_q + IW'(1);

	// Degree memory: cleared after reset, read on accept, written on add.
	assign dg_we    = cmd.clr_step || (cmd.eval && add_ok);
	assign dg_waddr = cmd.clr_step ? clr_cnt_q : src_idx;
	assign dg_wdata = cmd.clr_step ? '0 : deg_n;

	ales_ram #(
		.WIDTH(DW),
		.DEPTH(MAX_VERTICES)
	) u_deg_ram (
		.clk   (clk),
		.we    (dg_we),
		.waddr (dg_waddr),
		.wdata (dg_wdata),
		.re    (cmd.accept),
		.raddr (VA'(req.source_vertex)),
		.rdata (dg_rdata)
	);

	// Successor memory: one row of MAX_DEGREE entries per vertex.
	assign st_we    = cmd.eval && add_ok;
	assign st_waddr = base + SA'(deg_eff);
	assign st_re    = cmd.scan_start || cmd.scan_next;
	assign st_raddr = base + SA'(idx_n);

	ales_ram #(
		.WIDTH(VERTEX_W),
		.DEPTH(DEPTH)
	) u_succ_ram (
		.clk   (clk),
		.we    (st_we),
		.waddr (st_waddr),
		.wdata (snk_q),
		.re    (st_re),
		.raddr (st_raddr),
		.rdata (st_rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q  <= req.opcode;
			src_q <= req.source_vertex;
			snk_q <= req.sink_vertex;
		end
		if (cmd.eval) begin
			deg_q    <= deg_n;
			status_q <= status_n;
		end
		if (st_re) begin
			idx_q <= idx_n;
		end
		if (cmd.load_resp) begin
			rsp_q.status        <= status_q;
			rsp_q.edge_found    <= found_q;
			rsp_q.source_degree <= DEGREE_W'(deg_q);
			rsp_q.total_edges   <= total_q;
			rsp_q.listed_sink   <= '0;
			rsp_q.sink_valid    <= 1'b0;
			rsp_q.last          <= 1'b1;
		end else if (cmd.load_item) begin
			rsp_q.status        <= ST_OK;
			rsp_q.edge_found    <= 1'b0;
			rsp_q.source_degree <= DEGREE_W'(deg_q);
			rsp_q.total_edges   <= total_q;
			rsp_q.listed_sink   <= st_rdata;
			rsp_q.sink_valid    <= 1'b1;
			rsp_q.last          <= !stat.scan_more;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q     <= '0;
			vcount_q    <= VCOUNT_RESET;
			clr_cnt_q   <= '0;
			found_q     <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				vcount_q <= cfg_data;
			end
			if (cmd.clr_step) begin
				clr_cnt_q <= clr_cnt_q + VA'(1);
			end
			if (cmd.eval && add_ok) begin
				total_q <= total_q + TOTAL_W'(1);
			end
			if (cmd.eval) begin
				found_q <= 1'b0;
			end else if (cmd.found_set) begin
				found_q <= 1'b1;
			end
			if (cmd.load_resp || cmd.load_item) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign cfg_ready = 1'b1;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign stat.clr_done  = (clr_cnt_q == VA'(MAX_VERTICES - 1));
	assign stat.need_scan = need_scan;
	assign stat.is_list   = (op_q == OP_LIST);
	assign stat.out_free  = !rsp_valid_q || rsp_ready;
	assign stat.scan_more = (DW'(idx_q) + DW'(1)) < deg_q;
	assign stat.hit       = (st_rdata == snk_q);

endmodule

@@ src/ales_ctrl.sv @@
module ales_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	output ales_pkg::ctrl_cmd_t cmd,
	input  ales_pkg::dp_stat_t  stat
);

	import ales_pkg::*;

	localparam logic [2:0] S_CLEAR = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_DEG   = 3'd2;
	localparam logic [2:0] S_SCAN  = 3'd3;
	localparam logic [2:0] S_RESP  = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_n;

	always_comb begin
		cmd     = '0;
		state_n = state_q;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (stat.clr_done) begin
					state_n = S_IDLE;
				end
			end
			S_IDLE: begin
				if (req_valid) begin
					cmd.accept = 1'b1;
					state_n    = S_DEG;
				end
			end
			S_DEG: begin
				cmd.eval = 1'b1;
				if (stat.need_scan) begin
					cmd.scan_start = 1'b1;
					state_n        = S_SCAN;
				end else begin
					state_n = S_RESP;
				end
			end
			S_SCAN: begin
				if (stat.is_list) begin
					if (stat.out_free) begin
						cmd.load_item = 1'b1;
						if (stat.scan_more) begin
							cmd.scan_next = 1'b1;
						end else begin
							state_n = S_IDLE;
						end
					end
				end else if (stat.hit) begin
					cmd.found_set = 1'b1;
					state_n       = S_RESP;
				end else if (stat.scan_more) begin
					cmd.scan_next = 1'b1;
				end else begin
					state_n = S_RESP;
				end
			end
			S_RESP: begin
				if (stat.out_free) begin
					cmd.load_resp = 1'b1;
					state_n       = S_IDLE;
				end
			end
			default: begin
				state_n = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_n;
		end
	end

	assign req_ready = (state_q == S_IDLE);

endmodule

@@ src/adjacency_list_edge_store_unit.sv @@
// Directed graph store. Each vertex keeps an ordered list of up to MAX_DEGREE successors,
// and the block keeps a degree per vertex plus a 12-bit total edge count. A request item
// carries an opcode (add, query, list), a source and a sink vertex; add appends the sink
// to the source's list (duplicates allowed), query reports whether the sink is present,
// and list streams the source's successors in insertion order with last set on the final
// item (an empty list gives one item with sink_valid low). Every response item carries
// the source's degree and the edge total after the operation. Except for the unused
// opcode, a source at or beyond the configured vertex count, or such a sink for add or
// query, gives status "out of range", and an add to a full list gives status "full" and
// changes nothing. An add, a range error or an unused opcode goes through acceptance,
// degree read and evaluation to the response register; a query walks the successors in
// order, stopping at the first match; a list sends one item per successor, and an empty
// list gives its single item after evaluation. The walk is bounded by the single read
// port of the successor memory, which delivers one entry per cycle unless a list waits
// on the response side. Only one request is in flight at a time, but a finished response
// item sits in an output register, so the next request is accepted while it waits.
// After reset the degree memory is cleared, one vertex per cycle; requests are held off
// during that pass while configuration writes are taken at any time.
module adjacency_list_edge_store_unit #(
	parameter int MAX_VERTICES = ales_pkg::DEF_MAX_VERTICES,
	parameter int MAX_DEGREE   = ales_pkg::DEF_MAX_DEGREE
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         req_valid,
	output logic                         req_ready,
	input  ales_pkg::req_t               req,
	output logic                         rsp_valid,
	input  logic                         rsp_ready,
	output ales_pkg::rsp_t               rsp,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [ales_pkg::COUNT_W-1:0] cfg_data
);

	import ales_pkg::*;

	// Command and status between the sequencer and the datapath.
	ctrl_cmd_t cmd;
	dp_stat_t  stat;

	// The sequencer walks each request through degree lookup, evaluation and,
	// for query and list, the successor walk.
	ales_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.cmd       (cmd),
		.stat      (stat)
	);

	// The datapath holds both memories, the counters, the vertex count register
	// and the response register.
	ales_dpath #(
		.MAX_VERTICES(MAX_VERTICES),
		.MAX_DEGREE  (MAX_DEGREE)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.cmd       (cmd),
		.stat      (stat)
	);

endmodule

@@ src/ales_checker.sv @@
module ales_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           rsp_valid,
	input logic           rsp_ready,
	input ales_pkg::rsp_t rsp
);

	import ales_pkg::*;

	// A stalled response item stays put.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("response item changed while stalled");

	// Error responses are always the only item of their request.
	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status != ST_OK |-> rsp.last)
		else $error("error response without last");

	// Only listed successors may be followed by further items.
	a_nosink_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.sink_valid |-> rsp.last)
		else $error("non-list item without last");

	// A hit belongs to a successful query, never to a listed successor.
	a_found_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.edge_found |-> rsp.status == ST_OK && !rsp.sink_valid)
		else $error("edge_found on a wrong item");

endmodule

bind adjacency_list_edge_store_unit ales_checker u_ales_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.rsp_valid (rsp_valid),
	.rsp_ready (rsp_ready),
	.rsp       (rsp)
);

@@ bench/tb_top.sv @@
`timescale 1ns / 100ps

// Self-checking bench for the adjacency-list edge store.
// Requests are queued by the stimulus block and offered by a driver at the falling
// edge. A monitor at the rising edge predicts the response items of every accepted
// request and compares every accepted response item, field by field, with the oldest
// prediction still waiting.
module tb_top;

	import ales_pkg::*;

	localparam int MAXV          = DEF_MAX_VERTICES;
	localparam int MAXD          = DEF_MAX_DEGREE;
	localparam int SETTLE_CYCLES = 8;
	localparam int HOLD_CYCLES   = 300;
	localparam int NUM_FIELDS    = 7;

	// Idling modes. Each phase of the run picks one.
	typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

	logic                clk       = 1'b0;
	logic                arst_n    = 1'b0;
	logic                req_valid = 1'b0;
	logic                req_ready;
	req_t                req       = '0;
	logic                rsp_valid;
	logic                rsp_ready = 1'b0;
	rsp_t                rsp;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [COUNT_W-1:0]  cfg_data  = '0;

	adjacency_list_edge_store_unit #(
		.MAX_VERTICES(MAXV),
		.MAX_DEGREE  (MAXD)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	always #5 clk = ~clk;

	// Requests waiting to be offered, and responses predicted but not yet seen.
	req_t       pending_req[$];
	rsp_t       expected_rsp[$];
	idle_mode_t idle_mode = IDLE_NONE;

	// The driver counts what it offered, the monitor counts what was accepted.
	// An item is still on the bus while the two differ.
	int req_offered  = 0;
	int req_accepted = 0;

	// The stimulus block bumps hold_asked to ask for a long receiver hold-off.
	// The ready process notices the change and counts the stretch down itself.
	int hold_asked = 0;
	int hold_seen  = 0;
	int hold_left  = 0;

	// Shadow copy of the graph: successor lists, degrees, edge total and the
	// vertex count register as last written.
	logic [VERTEX_W-1:0] succ_of[MAXV][MAXD];
	logic [DEGREE_W-1:0] degree_of[MAXV];
	logic [TOTAL_W-1:0]  edge_sum = '0;
	logic [COUNT_W-1:0]  vcount   = VCOUNT_RESET;

	// Run statistics for the summary and the final verdict.
	int mismatches = 0;
	int n_rsp      = 0;
	int n_listed   = 0;
	int n_hits     = 0;
	int n_full     = 0;
	int n_range    = 0;
	int n_cfg      = 0;

	initial begin
		for (int v = 0; v < MAXV; v++) begin
			degree_of[v] = '0;
			for (int i = 0; i < MAXD; i++)
				succ_of[v][i] = '0;
		end
	end

	function automatic int live_count();
		return (vcount > MAXV) ? MAXV : int'(vcount);
	endfunction

	// Works out the response items of one accepted request and updates the
	// shadow graph the same way the block is supposed to.
	task automatic predict_graph_op(input req_t r);
		int                  n;
		bit                  src_ok;
		bit                  snk_ok;
		logic [DEGREE_W-1:0] d;
		rsp_t                e;
		n      = live_count();
		src_ok = int'(r.source_vertex) < n;
		snk_ok = int'(r.sink_vertex) < n;
		d      = src_ok ? degree_of[r.source_vertex] : '0;
		e               = '0;
		e.status        = ST_OK;
		e.source_degree = d;
		e.total_edges   = edge_sum;
		e.last          = 1'b1;
		if (r.opcode == OP_NOP) begin
			// The unused opcode checks no range and touches nothing.
			expected_rsp.push_back(e);
		end else if (!src_ok || (r.opcode != OP_LIST && !snk_ok)) begin
			e.status = ST_RANGE;
			n_range++;
			expected_rsp.push_back(e);
		end else begin
			case (r.opcode)
				OP_ADD: begin
					if (int'(d) >= MAXD) begin
						e.status = ST_FULL;
						n_full++;
					end else begin
						succ_of[r.source_vertex][d] = r.sink_vertex;
						d                            = d + 1'b1;
						degree_of[r.source_vertex]   = d;
						edge_sum                     = edge_sum + 1'b1;
						e.source_degree              = d;
						e.total_edges                = edge_sum;
					end
					expected_rsp.push_back(e);
				end
				OP_QUERY: begin
					for (int i = 0; i < int'(d); i++)
						if (succ_of[r.source_vertex][i] == r.sink_vertex)
							e.edge_found = 1'b1;
					if (e.edge_found)
						n_hits++;
					expected_rsp.push_back(e);
				end
				default: begin
					// List: an empty list still gives one item, with no sink.
					if (d == 0) begin
						expected_rsp.push_back(e);
					end else begin
						for (int i = 0; i < int'(d); i++) begin
							e.listed_sink = succ_of[r.source_vertex][i];
							e.sink_valid  = 1'b1;
							e.last        = (i == int'(d) - 1);
							expected_rsp.push_back(e);
						end
					end
				end
			endcase
		end
	endtask

	function automatic logic [TOTAL_W-1:0] rsp_field(rsp_t r, int k);
		case (k)
			0:       return TOTAL_W'(r.status);
			1:       return TOTAL_W'(r.edge_found);
			2:       return TOTAL_W'(r.source_degree);
			3:       return r.total_edges;
			4:       return TOTAL_W'(r.listed_sink);
			5:       return TOTAL_W'(r.sink_valid);
			default: return TOTAL_W'(r.last);
		endcase
	endfunction

	function automatic string rsp_field_name(int k);
		case (k)
			0:       return "status";
			1:       return "edge_found";
			2:       return "source_degree";
			3:       return "total_edges";
			4:       return "listed_sink";
			5:       return "sink_valid";
			default: return "last";
		endcase
	endfunction

	function automatic bit sender_idles();
		case (idle_mode)
			IDLE_SEND: return $urandom_range(0, 99) < 54;
			IDLE_BOTH: return $urandom_range(0, 99) < 13;
			default:   return 1'b0;
		endcase
	endfunction

	function automatic bit receiver_stalls();
		case (idle_mode)
			IDLE_RECV: return $urandom_range(0, 99) < 54;
			IDLE_BOTH: return $urandom_range(0, 99) < 13;
			default:   return 1'b0;
		endcase
	endfunction

	// Request driver. A new item, or a gap, is chosen only once the item on the
	// bus has been taken, so valid and payload hold steady while it waits.
	always @(negedge clk) begin
		if (!req_valid || req_accepted == req_offered) begin
			if (arst_n && pending_req.size() != 0 && !sender_idles()) begin
				req         <= pending_req.pop_front();
				req_valid   <= 1'b1;
				req_offered = req_offered + 1;
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	// Response ready. A requested hold-off keeps ready low for a long stretch so
	// that the output register fills and the block stops taking requests.
	always @(negedge clk) begin
		if (hold_asked != hold_seen) begin
			hold_seen = hold_asked;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			rsp_ready <= 1'b0;
		end else begin
			rsp_ready <= !receiver_stalls();
		end
	end

	// Monitor. Accepted requests feed the predictor; accepted response items are
	// checked against the oldest prediction.
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n) begin
			if (req_valid && req_ready) begin
				req_accepted = req_accepted + 1;
				predict_graph_op(req);
			end
			if (rsp_valid && rsp_ready) begin
				n_rsp++;
				if (rsp.sink_valid)
					n_listed++;
				if (expected_rsp.size() == 0) begin
					$display("%0t: response item %h arrived with nothing expected",
						$time, rsp);
					mismatches++;
				end else begin
					want = expected_rsp.pop_front();
					for (int k = 0; k < NUM_FIELDS; k++) begin
						if (rsp_field(rsp, k) !== rsp_field(want, k)) begin
							$display("%0t: %s mismatch, expected %0d, actual %0d",
								$time, rsp_field_name(k), rsp_field(want, k),
								rsp_field(rsp, k));
							mismatches++;
						end
					end
				end
			end
		end
	end

	task automatic queue_op(input logic [OP_W-1:0] op, input int src, input int snk);
		req_t r;
		r.opcode        = op;
		r.source_vertex = VERTEX_W'(src);
		r.sink_vertex   = VERTEX_W'(snk);
		pending_req.push_back(r);
	endtask

	// Mostly a vertex in use under the current count, now and then any label.
	function automatic int pick_vertex();
		int n;
		n = live_count();
		if (n == 0 || $urandom_range(0, 9) == 0)
			return $urandom_range(0, MAXV - 1);
		return $urandom_range(0, n - 1);
	endfunction

	// Random traffic. Most of it is a short build-and-probe sequence on one vertex:
	// a few adds, a query that must hit, a query of a random sink and a list. The
	// rest is lone items, fully random ones (unused opcode included) or a query or list.
	task automatic queue_random_traffic(input int n_items);
		int added;
		int kind;
		int src;
		int first_sink;
		int n_adds;
		added = 0;
		while (added < n_items) begin
			kind = $urandom_range(0, 9);
			if (kind < 5) begin
				src    = pick_vertex();
				n_adds = $urandom_range(1, 5);
				first_sink = pick_vertex();
				queue_op(OP_ADD, src, first_sink);
				for (int j = 1; j < n_adds; j++)
					queue_op(OP_ADD, src, pick_vertex());
				queue_op(OP_QUERY, src, first_sink);
				queue_op(OP_QUERY, src, pick_vertex());
				queue_op(OP_LIST, src, $urandom_range(0, MAXV - 1));
				added += n_adds + 3;
			end else if (kind < 8) begin
				queue_op(OP_W'($urandom_range(0, 3)), $urandom_range(0, MAXV - 1),
					$urandom_range(0, MAXV - 1));
				added++;
			end else begin
				queue_op(kind == 8 ? OP_LIST : OP_QUERY, pick_vertex(), pick_vertex());
				added++;
			end
		end
	endtask

	// Adds one more edge than a list can hold, so the last add at least is
	// rejected as full, then lists and queries the full vertex.
	task automatic queue_fill(input int src);
		for (int i = 0; i <= MAXD; i++)
			queue_op(OP_ADD, src, $urandom_range(0, MAXV - 1));
		queue_op(OP_LIST, src, 0);
		queue_op(OP_QUERY, src, $urandom_range(0, MAXV - 1));
	endtask

	// Waits until no request is queued or on the bus and every predicted
	// response has arrived, then lets the block settle.
	task automatic wait_quiet();
		while (pending_req.size() != 0 || req_valid || req_offered != req_accepted ||
			expected_rsp.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Writes the vertex count register; only called while the block is quiet.
	task automatic write_vertex_count(input int value);
		@(negedge clk);
		cfg_data  <= COUNT_W'(value);
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		vcount = COUNT_W'(value);
		n_cfg++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part, reset count of 64: both ends of the vertex range, a
		// duplicate edge, a hit, a miss, a query on an empty list, a list of
		// several, an empty list and the unused opcode.
		queue_op(OP_ADD, 0, 63);
		queue_op(OP_ADD, 63, 0);
		queue_op(OP_ADD, 0, 0);
		queue_op(OP_ADD, 0, 63);
		queue_op(OP_QUERY, 0, 63);
		queue_op(OP_QUERY, 0, 5);
		queue_op(OP_QUERY, 1, 0);
		queue_op(OP_LIST, 0, 17);
		queue_op(OP_LIST, 5, 0);
		queue_op(OP_NOP, 0, 63);
		queue_op(OP_NOP, 63, 0);
		wait_quiet();

		// Shrunk count: out-of-range sink and source, the unused opcode on a
		// vertex out of range, and edges stored earlier still listed.
		write_vertex_count(4);
		queue_op(OP_ADD, 2, 9);
		queue_op(OP_ADD, 9, 1);
		queue_op(OP_QUERY, 1, 40);
		queue_op(OP_LIST, 40, 0);
		queue_op(OP_NOP, 50, 3);
		queue_op(OP_NOP, 0, 0);
		queue_op(OP_LIST, 0, 0);
		queue_op(OP_QUERY, 0, 63);
		wait_quiet();

		// A count of zero puts every vertex out of range.
		write_vertex_count(0);
		queue_op(OP_ADD, 0, 0);
		queue_op(OP_LIST, 0, 0);
		queue_op(OP_NOP, 0, 0);
		wait_quiet();

		// The smallest useful count, then the largest register value, which acts
		// as the full vertex range.
		write_vertex_count(1);
		queue_op(OP_ADD, 0, 0);
		queue_op(OP_QUERY, 0, 0);
		wait_quiet();
		write_vertex_count(127);
		queue_op(OP_ADD, 63, 62);
		queue_op(OP_LIST, 63, 0);
		wait_quiet();

		// Random part, one phase per idling mode.
		write_vertex_count(64);
		idle_mode = IDLE_NONE;
		queue_random_traffic(35);
		wait_quiet();

		write_vertex_count(127);
		idle_mode = IDLE_SEND;
		queue_random_traffic(35);
		wait_quiet();

		// Back pressure: fill one list while the receiver holds off, so the
		// request side backs up behind the output register.
		write_vertex_count(64);
		idle_mode = IDLE_RECV;
		queue_fill(63);
		queue_random_traffic(15);
		@(posedge clk);
		hold_asked = hold_asked + 1;
		wait_quiet();

		write_vertex_count($urandom_range(2, 63));
		idle_mode = IDLE_BOTH;
		queue_random_traffic(30);
		wait_quiet();

		$display("Checked %0d request items and %0d response items (%0d listed sinks).",
			req_accepted, n_rsp, n_listed);
		$display("Saw %0d query hits, %0d full rejects, %0d range errors, %0d count writes.",
			n_hits, n_full, n_range, n_cfg);
		if (mismatches == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

	// Watchdog, far beyond the slowest correct run including the hold-off.
	initial begin
		#3000000;
		$display("Timeout with %0d response items still expected", expected_rsp.size());
		$display("Simulation FAILED");
		$finish;
	end

endmodule
